// File: rtl/cfbd_pkg.sv
// shared types and constants for the can frame byte deframer
package cfbd_pkg;

   localparam int RecBytes  = 16;
   localparam int MaxLen    = 8;
   localparam int IdBits    = 29;
   localparam int LenBits   = 4;
   localparam int PayBits   = MaxLen * 8;
   localparam int CountBits = $clog2(RecBytes);
   localparam int ErrBitPos = 29;
   localparam int EffBitPos = 31;

   // byte offsets inside one record
   localparam int LenByte  = 4;
   localparam int DataByte = 8;

   localparam logic [CountBits-1:0] LastPos = CountBits'(RecBytes - 1);
   localparam logic [7:0]           MaxLenByte = 8'(MaxLen);

   typedef logic [RecBytes-1:0][7:0] record_type;

   // gathered record handed to the decoder
   typedef struct packed {
      logic       fire;
      record_type record;
   } gather_out_type;

   // gatherer status seen by the top level
   typedef struct packed {
      logic                 fault;
      logic [CountBits-1:0] count;
   } gather_status_type;

   function automatic logic [31:0] id_word(input record_type rec);
      id_word = {rec[3], rec[2], rec[1], rec[0]};
   endfunction

endpackage

// File: rtl/cfbd_stream_if.sv
// request and response channel interfaces
interface cfbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface cfbd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cfbd_pkg::IdBits-1:0]         frame_id;
   logic                                is_extended;
   logic [cfbd_pkg::LenBits-1:0]        data_length;
   logic [cfbd_pkg::PayBits-1:0]        payload;
   logic                                frame_status;

   modport source (output valid, output frame_id, output is_extended, output data_length,
                   output payload, output frame_status, input ready);
   modport sink (input valid, input frame_id, input is_extended, input data_length,
                 input payload, input frame_status, output ready);
endinterface

// File: rtl/cfbd_gather.sv
// byte gatherer: position counter, record store and sticky fault
module cfbd_gather (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [7:0]                  req_data_byte,
   output logic                        req_ready,
   input  logic                        out_free,
   output cfbd_pkg::gather_out_type    gather_out,
   output cfbd_pkg::gather_status_type status
);
   import cfbd_pkg::*;

   logic [CountBits-1:0] count_ff, count_in;
   logic                 fault_ff, fault_in;
   logic [7:0]           store_ff [0:RecBytes-2];
   logic                 accept;
   logic                 take;
   logic                 at_last;
   record_type           rec_view;

   assign at_last   = (count_ff == LastPos);
   // only the closing byte of a record needs room in the result register
   assign req_ready = fault_ff || !at_last || out_free;
   assign accept    = req_valid && req_ready;
   assign take      = accept && !fault_ff;

   always_comb begin
      for (int i = 0; i < RecBytes - 1; i++) begin
         rec_view[i] = store_ff[i];
      end
      rec_view[RecBytes-1] = req_data_byte;
   end

   always_comb begin
      count_in = count_ff;
      fault_in = fault_ff;
      if (take) begin
         count_in = count_ff + CountBits'(1);
         if (at_last && rec_view[3][ErrBitPos-24]) begin
            fault_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fault_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !at_last) begin
         store_ff[count_ff] <= req_data_byte;
      end
   end

   assign gather_out.fire   = take && at_last;
   assign gather_out.record = rec_view;
   assign status.fault      = fault_ff;
   assign status.count      = count_ff;

endmodule

// File: rtl/cfbd_decode.sv
// record decoder and result register
module cfbd_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  cfbd_pkg::gather_out_type     gather_out,
   output logic                         out_free,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cfbd_pkg::IdBits-1:0]  rsp_frame_id,
   output logic                         rsp_is_extended,
   output logic [cfbd_pkg::LenBits-1:0] rsp_data_length,
   output logic [cfbd_pkg::PayBits-1:0] rsp_payload,
   output logic                         rsp_frame_status
);
   import cfbd_pkg::*;

   logic               valid_ff, valid_in;
   logic [IdBits-1:0]  id_ff, id_in;
   logic               ext_ff, ext_in;
   logic [LenBits-1:0] len_ff, len_in;
   logic [PayBits-1:0] pay_ff, pay_in;
   logic               status_ff, status_in;
   logic [31:0]        word;
   logic [LenBits-1:0] len_clamped;

   assign word        = id_word(gather_out.record);
   assign len_clamped = (gather_out.record[LenByte] > MaxLenByte) ?
                        LenBits'(MaxLen) : gather_out.record[LenByte][LenBits-1:0];

   always_comb begin
      id_in     = word[IdBits-1:0];
      ext_in    = word[EffBitPos];
      len_in    = len_clamped;
      status_in = 1'b0;
      for (int i = 0; i < MaxLen; i++) begin
         pay_in[i*8 +: 8] = (LenBits'(i) < len_clamped) ? gather_out.record[DataByte+i] : 8'h00;
      end
      // malformed record reports status only
      if (word[ErrBitPos]) begin
         id_in     = '0;
         ext_in    = 1'b0;
         len_in    = '0;
         pay_in    = '0;
         status_in = 1'b1;
      end
   end

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (gather_out.fire) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gather_out.fire) begin
         id_ff     <= id_in;
         ext_ff    <= ext_in;
         len_ff    <= len_in;
         pay_ff    <= pay_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_id     = id_ff;
   assign rsp_is_extended  = ext_ff;
   assign rsp_data_length  = len_ff;
   assign rsp_payload      = pay_ff;
   assign rsp_frame_status = status_ff;

endmodule

// File: rtl/can_frame_byte_deframer_core.sv
// a decoded frame is registered and appears in the cycle after the request carrying its 16th byte
// throughput: one byte request per cycle; the closing byte of a record waits only
//   while the single result register still holds an untaken frame
// reset: synchronous, clears the byte position, the fault flag and the result valid
// after a malformed frame every later request is taken and dropped until reset
module can_frame_byte_deframer_core (
   input logic          clock,
   input logic          reset,
   cfbd_req_if.sink     req_chan,
   cfbd_rsp_if.source   rsp_chan
);
   import cfbd_pkg::*;

   gather_out_type    gather_out;
   gather_status_type status;
   logic              out_free;

   cfbd_gather u_gather (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_data_byte (req_chan.data_byte),
      .req_ready     (req_chan.ready),
      .out_free      (out_free),
      .gather_out    (gather_out),
      .status        (status)
   );

   cfbd_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .gather_out       (gather_out),
      .out_free         (out_free),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_frame_id     (rsp_chan.frame_id),
      .rsp_is_extended  (rsp_chan.is_extended),
      .rsp_data_length  (rsp_chan.data_length),
      .rsp_payload      (rsp_chan.payload),
      .rsp_frame_status (rsp_chan.frame_status)
   );

`ifndef SYNTHESIS
   // fault is sticky until reset
   assert property (@(posedge clock) disable iff (reset) status.fault |=> status.fault)
      else $error("fault flag dropped without reset");

   // a malformed frame always leaves the block faulted
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_status |-> status.fault)
      else $error("malformed frame without fault");

   // malformed status carries no frame contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_status |->
      rsp_chan.frame_id == '0 && rsp_chan.payload == '0 && rsp_chan.data_length == '0)
      else $error("malformed frame with nonzero fields");

   // once faulted, no new frame may be loaded
   assert property (@(posedge clock) disable iff (reset)
      status.fault && !rsp_chan.valid |=> !rsp_chan.valid)
      else $error("frame produced while faulted");

   // a frame is only produced at the closing byte position
   assert property (@(posedge clock) disable iff (reset)
      gather_out.fire |-> status.count == LastPos && out_free)
      else $error("frame fired at wrong position");
`endif

endmodule

// File: verif/tb.sv
// self-checking testbench for the can frame byte deframer core
`timescale 1ns / 100ps

module tb;
   import cfbd_pkg::*;

   localparam logic StatusGood      = 1'b0;
   localparam logic StatusMalformed = 1'b1;
   localparam int   StallLimit      = 5000;
   localparam int   RandRecords     = 95;
   localparam int   NoiseBytes      = 20;
   localparam int   HoldStart       = 1100;
   localparam int   HoldCycles      = 250;
   localparam int   IdlePct         = 6;

   typedef struct packed {
      logic [IdBits-1:0]  frame_id;
      logic               is_extended;
      logic [LenBits-1:0] data_length;
      logic [PayBits-1:0] payload;
      logic               frame_status;
   } can_frame_type;

   // one 16-byte record as sent, with an optional hand-written decode
   typedef struct packed {
      logic [31:0]        word;
      logic [7:0]         len_byte;
      logic [23:0]        spare;
      logic [PayBits-1:0] data;
      logic               known;
      can_frame_type      frame;
   } record_row_type;

   logic clock = 1'b0;
   logic reset;
   logic calm;

   cfbd_req_if req_chan ();
   cfbd_rsp_if rsp_chan ();

   can_frame_byte_deframer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   record_row_type dir_rows [6] = '{
      '{32'h0000_0000, 8'd0, 24'h00_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{29'h0, 1'b0, 4'd0, 64'h0, StatusGood}},
      '{32'hDFFF_FFFF, 8'd8, 24'hFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{29'h1FFF_FFFF, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, StatusGood}},
      '{32'h4000_0000, 8'hFF, 24'h00_0000, 64'h0123_4567_89AB_CDEF, 1'b1,
        '{29'h0, 1'b0, 4'd8, 64'h0123_4567_89AB_CDEF, StatusGood}},
      '{32'h9234_5678, 8'd3, 24'hA5_A5A5, 64'h1122_3344_5566_7788, 1'b1,
        '{29'h1234_5678, 1'b1, 4'd3, 64'h0000_0000_0066_7788, StatusGood}},
      '{32'h8765_4321, 8'd9, 24'h5A_5A5A, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
      '{32'h1FFF_FFFF, 8'd1, 24'h00_0000, 64'h0000_0000_0000_00AB, 1'b0, '0}
   };

   // predictor state
   logic [3:0] rec_pos;
   logic [7:0] rec_bytes [RecBytes];
   logic       halted;

   can_frame_type  expected_frames [$];
   record_row_type record_plan [$];
   int             mismatches;
   int             quiet_cycles;

   function automatic void deframe_byte(input logic [7:0] b, output logic got,
                                        output can_frame_type f);
      logic [31:0] word;
      int          n;
      got = 1'b0;
      f   = '0;
      if (halted)
         return;
      rec_bytes[rec_pos] = b;
      if (rec_pos != 4'(RecBytes - 1)) begin
         rec_pos = rec_pos + 4'd1;
         return;
      end
      rec_pos = '0;
      got     = 1'b1;
      word    = {rec_bytes[3], rec_bytes[2], rec_bytes[1], rec_bytes[0]};
      if (word[ErrBitPos]) begin
         f.frame_status = StatusMalformed;
         halted         = 1'b1;
         return;
      end
      n = (rec_bytes[LenByte] > MaxLen) ? MaxLen : int'(rec_bytes[LenByte]);
      f.frame_id     = word[IdBits-1:0];
      f.is_extended  = word[EffBitPos];
      f.data_length  = LenBits'(n);
      for (int i = 0; i < n; i++)
         f.payload[8*i +: 8] = rec_bytes[DataByte + i];
      f.frame_status = StatusGood;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch: %s", msg);
   endtask

   task automatic put_byte(input logic [7:0] b);
      if (!calm && $urandom_range(99) < IdlePct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_record(input record_row_type r);
      logic [7:0] bytes [RecBytes];
      record_plan = {record_plan, r};
      for (int i = 0; i < 4; i++)
         bytes[i] = r.word[8*i +: 8];
      bytes[LenByte] = r.len_byte;
      for (int i = 0; i < 3; i++)
         bytes[LenByte + 1 + i] = r.spare[8*i +: 8];
      for (int i = 0; i < MaxLen; i++)
         bytes[DataByte + i] = r.data[8*i +: 8];
      for (int i = 0; i < RecBytes; i++)
         put_byte(bytes[i]);
   endtask

   function automatic record_row_type random_record();
      record_row_type r;
      r = '0;
      r.word = $urandom;
      r.word[ErrBitPos] = 1'b0;
      // mostly legal lengths, sometimes anything up to 255
      r.len_byte = ($urandom_range(99) < 70) ? 8'($urandom_range(MaxLen)) : 8'($urandom);
      r.spare = 24'($urandom);
      r.data  = {$urandom, $urandom};
      return r;
   endfunction

   // request and result monitor, predictor and stall watchdog
   always @(posedge clock) begin
      logic           got;
      logic           moved;
      can_frame_type  pred;
      can_frame_type  want;
      can_frame_type  seen;
      record_row_type row;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            seen  = {rsp_chan.frame_id, rsp_chan.is_extended, rsp_chan.data_length,
                     rsp_chan.payload, rsp_chan.frame_status};
            if (expected_frames.size() == 0) begin
               flag_mismatch($sformatf("unexpected frame id %h status %0b",
                                       seen.frame_id, seen.frame_status));
            end else begin
               want = expected_frames.pop_front();
               if (seen.frame_id !== want.frame_id || seen.is_extended !== want.is_extended
                   || seen.data_length !== want.data_length
                   || seen.payload !== want.payload
                   || seen.frame_status !== want.frame_status)
                  flag_mismatch($sformatf(
                     "exp/act id %h/%h ext %0b/%0b len %0d/%0d pay %h/%h status %0b/%0b",
                     want.frame_id, seen.frame_id, want.is_extended, seen.is_extended,
                     want.data_length, seen.data_length, want.payload, seen.payload,
                     want.frame_status, seen.frame_status));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            deframe_byte(req_chan.data_byte, got, pred);
            if (got) begin
               if (record_plan.size() != 0) begin
                  row = record_plan.pop_front();
                  expected_frames = {expected_frames, (row.known ? row.frame : pred)};
               end else begin
                  expected_frames = {expected_frames, pred};
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stalls, a calm stretch and one long hold-off
   initial begin
      int cyc;
      cyc = 0;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (cyc >= HoldStart && cyc < HoldStart + HoldCycles)
            rsp_chan.ready <= 1'b0;
         else if (calm)
            rsp_chan.ready <= 1'b1;
         else
            rsp_chan.ready <= ($urandom_range(99) >= IdlePct);
         @(posedge clock);
         cyc++;
      end
   end

   initial begin
      record_row_type fault_row;
      reset              = 1'b1;
      calm               = 1'b0;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = 8'h00;
      rec_pos            = '0;
      halted             = 1'b0;
      mismatches         = 0;
      quiet_cycles       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_record(dir_rows[i]);

      for (int k = 0; k < RandRecords; k++) begin
         calm = (k >= 30 && k < 50);
         send_record(random_record());
      end
      calm = 1'b0;

      // error flag ends the stream: block halts and drops the rest
      fault_row = random_record();
      fault_row.word[ErrBitPos] = 1'b1;
      fault_row.known = 1'b1;
      fault_row.frame = '{29'h0, 1'b0, 4'd0, 64'h0, StatusMalformed};
      send_record(fault_row);
      repeat (NoiseBytes) put_byte(8'($urandom));
      req_chan.valid <= 1'b0;

      while (expected_frames.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
